// File: sv/quadrature_speed_matcher_unit_macros.svh
// Assertion helpers for the speed matcher.
// Every check is sampled on i_clk and is off while i_rst_n is low.
`ifndef QUADRATURE_SPEED_MATCHER_UNIT_MACROS_SVH
`define QUADRATURE_SPEED_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define QSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/qsm_pkg.sv
`default_nettype none

package qsm_pkg;

    // Field and datapath widths.
    localparam int GAIN_W     = 10;
    localparam int DRIVE_W    = 14;
    localparam int TARGET_W   = 15;
    localparam int DELTA_W    = 32;
    localparam int ERR_W      = 18;
    localparam int PROD_W     = 28;
    localparam int CFG_IDX_W  = 1;
    localparam int ERR_LIMIT  = 65536;

    // Default counter width.
    localparam int COUNT_WIDTH_DEF = 32;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]  LOOP_GAIN_RST = GAIN_W'(40);
    localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST = DRIVE_W'(10000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE = 1'b1;

    // Count step, indexed by {new phase, old phase}, phase = 2*B + A.
    localparam logic signed [2:0] STEP_TABLE [16] = '{
        3'sd0,  3'sd1,  -3'sd1, 3'sd2,
        -3'sd1, 3'sd0,  -3'sd2, 3'sd1,
        3'sd1,  -3'sd2, 3'sd0,  -3'sd1,
        3'sd2,  -3'sd1, 3'sd1,  3'sd0
    };

    // Control of one quadrature counter.
    typedef struct packed {
        logic sample;
        logic tick;
    } t_cnt_ctrl;

    // Control of the drive stages.
    typedef struct packed {
        logic prod_en;
        logic target_en;
    } t_drv_ctrl;

endpackage

`default_nettype wire

// File: sv/qsm_quad_counter.sv
`default_nettype none

module qsm_quad_counter #(
    parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  qsm_pkg::t_cnt_ctrl           i_ctrl,
    input  wire                          i_phase_a,
    input  wire                          i_phase_b,
    output logic signed [COUNT_WIDTH-1:0] o_count
);
    import qsm_pkg::*;

    logic [1:0]                    r_last;
    logic [COUNT_WIDTH-1:0]        r_count;
    logic [1:0]                    cur_phase;
    logic signed [2:0]             step;
    logic signed [COUNT_WIDTH-1:0] step_ext;

    // Decode the step from the previous and present phase pair.
    assign cur_phase = {i_phase_b, i_phase_a};
    assign step      = STEP_TABLE[{cur_phase, r_last}];
    assign step_ext  = COUNT_WIDTH'(step);

    // The count holds the change since the last control tick and wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 2'b00;
            r_count <= '0;
        end else if (i_ctrl.sample) begin
            r_last  <= cur_phase;
            r_count <= r_count + step_ext;
        end else if (i_ctrl.tick) begin
            r_count <= '0;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// File: sv/qsm_drive.sv
`default_nettype none

module qsm_drive (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  qsm_pkg::t_drv_ctrl                   i_ctrl,
    input  wire signed [qsm_pkg::ERR_W-1:0]      i_err,
    input  wire [qsm_pkg::GAIN_W-1:0]            i_loop_gain,
    input  wire [qsm_pkg::DRIVE_W-1:0]           i_max_drive,
    output logic signed [qsm_pkg::TARGET_W-1:0]  o_target_next
);
    import qsm_pkg::*;

    logic signed [PROD_W-1:0]       r_prod;
    logic signed [TARGET_W-1:0]     r_target;
    logic signed [GAIN_W+ERR_W:0]   mult_full;
    logic signed [PROD_W-1:0]       sum;
    logic signed [PROD_W-1:0]       lim_hi;
    logic signed [PROD_W-1:0]       lim_lo;
    logic signed [PROD_W-1:0]       n_sat;

    // Gain times error, registered before the accumulate.
    assign mult_full = $signed({1'b0, i_loop_gain}) * i_err;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_en) begin
            r_prod <= mult_full[PROD_W-1:0];
        end
    end

    // Accumulate into the target and clamp to the drive limit.
    assign sum    = PROD_W'(r_target) + r_prod;
    assign lim_hi = $signed({{(PROD_W-DRIVE_W){1'b0}}, i_max_drive});
    assign lim_lo = -lim_hi;

    always_comb begin
        priority if (sum > lim_hi) begin
            n_sat = lim_hi;
        end else if (sum < lim_lo) begin
            n_sat = lim_lo;
        end else begin
            n_sat = sum;
        end
    end

    assign o_target_next = n_sat[TARGET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_ctrl.target_en) begin
            r_target <= o_target_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/quadrature_speed_matcher_unit.sv
// Quadrature speed matcher: two quadrature decoders and a proportional
// wheel-speed matcher.
// Input channel (i_in_valid / o_in_stall): one request per clock, while o_in_stall
// is low, carries kind and the four phase levels. Kind 0 is an encoder sample
// and gives no result; kind 1 is a control tick and gives one result request.
// Output channel (o_out_valid / i_out_stall): direction bits, duty and the
// left and right count deltas since the previous tick.
// A tick passes the input, error and product registers and then the result
// register on its way to the output.
// Throughput: one request per cycle while o_in_stall is low; the counters and
// the drive target each take their update without holding the flow.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; index 0 is the
// loop gain, index 1 the drive limit. Write it only while the block is idle.
// Reset clears counters, phases and the drive target, and restores gain 40
// and limit 10000. When the receiver stalls, the output holds and later ticks
// wait in the product and error stages while samples keep flowing. Once both
// stages hold ticks, the request in the input register waits and the input
// stalls.
`default_nettype none

module quadrature_speed_matcher_unit #(
    parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Input request channel.
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_kind,
    input  wire                                  i_right_phase_a,
    input  wire                                  i_right_phase_b,
    input  wire                                  i_left_phase_a,
    input  wire                                  i_left_phase_b,
    // Result request channel.
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_drive_forward,
    output logic                                 o_drive_reverse,
    output logic [qsm_pkg::DRIVE_W-1:0]          o_drive_duty,
    output logic signed [qsm_pkg::DELTA_W-1:0]   o_left_delta,
    output logic signed [qsm_pkg::DELTA_W-1:0]   o_right_delta,
    // Configuration write channel.
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [qsm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [qsm_pkg::DRIVE_W-1:0]           i_cfg_data
);
    import qsm_pkg::*;

    localparam int EW = (COUNT_WIDTH + 1 > ERR_W) ? COUNT_WIDTH + 1 : ERR_W;
    localparam int DW = (COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W;
    localparam logic signed [EW-1:0] E_HI = EW'(ERR_LIMIT);
    localparam logic signed [EW-1:0] E_LO = -E_HI;

    // Configuration registers.
    logic [GAIN_W-1:0]  r_loop_gain;
    logic [DRIVE_W-1:0] r_max_drive;

    // Stage enables.
    logic en0, en1, en2, en3;

    // Input stage.
    logic r_in_valid;
    logic r_in_kind;
    logic r_in_ra, r_in_rb, r_in_la, r_in_lb;

    // Error stage.
    logic                        r_s1_valid;
    logic signed [ERR_W-1:0]     r_s1_err;
    logic signed [DELTA_W-1:0]   r_s1_ld, r_s1_rd;

    // Product stage.
    logic                        r_s2_valid;
    logic signed [DELTA_W-1:0]   r_s2_ld, r_s2_rd;

    // Counters and error arithmetic.
    t_cnt_ctrl                     cnt_ctrl;
    t_drv_ctrl                     drv_ctrl;
    logic signed [COUNT_WIDTH-1:0] left_count, right_count;
    logic signed [EW-1:0]          err_wide;
    logic signed [ERR_W-1:0]       err_sat;
    logic signed [DW-1:0]          ld_ext, rd_ext;
    logic signed [TARGET_W-1:0]    target_next;
    logic [TARGET_W-1:0]           target_mag;

    // Each stage moves when it is empty or the stage after it moves.
    assign en3        = !o_out_valid || !i_out_stall;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign en0        = !r_in_valid || en1;
    assign o_in_stall = !en0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_gain <= LOOP_GAIN_RST;
            r_max_drive <= MAX_DRIVE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOOP_GAIN: r_loop_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MAX_DRIVE: r_max_drive <= i_cfg_data;
                default:       r_max_drive <= r_max_drive;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en0) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_ra   <= i_right_phase_a;
            r_in_rb   <= i_right_phase_b;
            r_in_la   <= i_left_phase_a;
            r_in_lb   <= i_left_phase_b;
        end
    end

    // Counters step on samples and clear on ticks as the request leaves
    // the input register.
    assign cnt_ctrl.sample = r_in_valid && en1 && !r_in_kind;
    assign cnt_ctrl.tick   = r_in_valid && en1 && r_in_kind;

    qsm_quad_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_left_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (cnt_ctrl),
        .i_phase_a (r_in_la),
        .i_phase_b (r_in_lb),
        .o_count   (left_count)
    );

    qsm_quad_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_right_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (cnt_ctrl),
        .i_phase_a (r_in_ra),
        .i_phase_b (r_in_rb),
        .o_count   (right_count)
    );

    // Exact error of the signed deltas, clamped to the error limit.
    assign err_wide = EW'(left_count) - EW'(right_count);

    always_comb begin
        priority if (err_wide > E_HI) begin
            err_sat = ERR_W'(E_HI);
        end else if (err_wide < E_LO) begin
            err_sat = ERR_W'(E_LO);
        end else begin
            err_sat = ERR_W'(err_wide);
        end
    end

    // Deltas are sign-extended or cut to the output width.
    assign ld_ext = DW'(left_count);
    assign rd_ext = DW'(right_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= r_in_valid && r_in_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_ctrl.tick) begin
            r_s1_err <= err_sat;
            r_s1_ld  <= ld_ext[DELTA_W-1:0];
            r_s1_rd  <= rd_ext[DELTA_W-1:0];
        end
    end

    // Product stage and drive accumulate.
    assign drv_ctrl.prod_en   = en2 && r_s1_valid;
    assign drv_ctrl.target_en = en3 && r_s2_valid;

    qsm_drive u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (drv_ctrl),
        .i_err         (r_s1_err),
        .i_loop_gain   (r_loop_gain),
        .i_max_drive   (r_max_drive),
        .o_target_next (target_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drv_ctrl.prod_en) begin
            r_s2_ld <= r_s1_ld;
            r_s2_rd <= r_s1_rd;
        end
    end

    // Result register.
    assign target_mag = target_next[TARGET_W-1] ? -target_next : target_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en3) begin
            o_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drv_ctrl.target_en) begin
            o_drive_forward <= !target_next[TARGET_W-1] && (target_next != '0);
            o_drive_reverse <= target_next[TARGET_W-1];
            o_drive_duty    <= target_mag[DRIVE_W-1:0];
            o_left_delta    <= r_s2_ld;
            o_right_delta   <= r_s2_rd;
        end
    end

    // Checks on the pipeline and the result encoding.
    `include "quadrature_speed_matcher_unit_macros.svh"

    `QSM_ASSERT_IMP(a_dir_excl, o_out_valid, !(o_drive_forward && o_drive_reverse), "both directions set")
    `QSM_ASSERT_IMP(a_coast, o_out_valid, ((o_drive_duty == '0) == (!o_drive_forward && !o_drive_reverse)), "duty and direction disagree")
    `QSM_ASSERT_IMP(a_stall_full, o_in_stall, r_in_valid && r_s1_valid && r_s2_valid, "stall with a free stage")
    `QSM_ASSERT_NXT(a_tick_moves, cnt_ctrl.tick, r_s1_valid, "tick lost at error stage")

endmodule

`default_nettype wire

// File: tb/tb_quadrature_speed_matcher_unit.sv
`default_nettype none

module tb_quadrature_speed_matcher_unit;

    import qsm_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    // One input request: kind and the phase pairs as {B, A}.
    typedef struct packed {
        logic       kind;
        logic [1:0] left_phase;
        logic [1:0] right_phase;
    } t_request;

    // One drive update as the block reports it.
    typedef struct {
        logic                      fwd;
        logic                      rev;
        logic [DRIVE_W-1:0]        duty;
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
    } t_drive_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_kind = 1'b0;
    logic                      i_right_phase_a = 1'b0;
    logic                      i_right_phase_b = 1'b0;
    logic                      i_left_phase_a = 1'b0;
    logic                      i_left_phase_b = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_drive_forward;
    logic                      o_drive_reverse;
    logic [DRIVE_W-1:0]        o_drive_duty;
    logic signed [DELTA_W-1:0] o_left_delta;
    logic signed [DELTA_W-1:0] o_right_delta;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [DRIVE_W-1:0]        i_cfg_data = '0;

    quadrature_speed_matcher_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_right_phase_a(i_right_phase_a),
        .i_right_phase_b(i_right_phase_b),
        .i_left_phase_a (i_left_phase_a),
        .i_left_phase_b (i_left_phase_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_forward(o_drive_forward),
        .o_drive_reverse(o_drive_reverse),
        .o_drive_duty   (o_drive_duty),
        .o_left_delta   (o_left_delta),
        .o_right_delta  (o_right_delta),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock generation.
    always #2 i_clk = ~i_clk;

    t_request      pending_requests[$];
    t_drive_result expected_drives[$];

    // Shadow of the block state used to predict each drive update.
    logic [1:0]  left_prev_phase = '0;
    logic [1:0]  right_prev_phase = '0;
    logic [31:0] left_count = '0;
    logic [31:0] right_count = '0;
    logic [31:0] left_mark = '0;
    logic [31:0] right_mark = '0;
    longint      drive_level = 0;
    int          gain_setting = 40;
    int          limit_setting = 10000;

    // Handshake bookkeeping and counters.
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int accepted_requests = 0;
    int drives_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Idle pattern state for both sides and the long receiver hold.
    int send_gap = 0;
    int send_run = 0;
    bit send_quiet = 1'b0;
    int recv_wait = 0;
    int recv_run = 0;
    bit recv_quiet = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Generator position of each encoder along its forward cycle.
    int gen_left_rank = 0;
    int gen_right_rank = 0;
    int gen_left_dir = 1;
    int gen_right_dir = 1;
    int gen_left_pct = 50;
    int gen_right_pct = 50;

    // Count change for one phase transition. Ranks follow the forward
    // cycle 0, 2, 3, 1, so a rank step of one is a single edge.
    function automatic int count_step(logic [1:0] old_ph, logic [1:0] new_ph);
        logic [1:0] old_rank;
        logic [1:0] new_rank;
        logic [1:0] diff;
        old_rank = {old_ph[0], old_ph[0] ^ old_ph[1]};
        new_rank = {new_ph[0], new_ph[0] ^ new_ph[1]};
        diff = new_rank - old_rank;
        case (diff)
            2'd1: return 1;
            2'd3: return -1;
            // A skipped edge counts forward between 0 and 3, backward otherwise.
            2'd2: return (old_ph == 2'd0 || old_ph == 2'd3) ? 2 : -2;
            default: return 0;
        endcase
    endfunction

    // Control tick: take the deltas, update the drive level and report it.
    function automatic t_drive_result track_tick();
        t_drive_result res;
        logic signed [31:0] ld;
        logic signed [31:0] rd;
        longint err;
        longint lvl;
        ld = left_count - left_mark;
        rd = right_count - right_mark;
        left_mark = left_count;
        right_mark = right_count;
        err = longint'(ld) - longint'(rd);
        if (err > ERR_LIMIT) err = ERR_LIMIT;
        if (err < -ERR_LIMIT) err = -ERR_LIMIT;
        lvl = drive_level + longint'(gain_setting) * err;
        if (lvl > limit_setting) lvl = limit_setting;
        if (lvl < -limit_setting) lvl = -limit_setting;
        drive_level = lvl;
        res.fwd = (lvl > 0);
        res.rev = (lvl < 0);
        res.duty = DRIVE_W'(lvl < 0 ? -lvl : lvl);
        res.left_delta = ld;
        res.right_delta = rd;
        return res;
    endfunction

    // Idle cycles for one request: runs with no idling mix at random with runs
    // of random gaps.
    function automatic int draw_idle(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            quiet = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Sample the handshakes, keep the shadow state and check results.
    always @(posedge i_clk) begin : observe
        t_drive_result want;
        logic [1:0] lph;
        logic [1:0] rph;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOOP_GAIN: gain_setting = i_cfg_data[GAIN_W-1:0];
                CFG_MAX_DRIVE: limit_setting = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            accepted_requests++;
            if (i_kind) begin
                expected_drives.push_back(track_tick());
            end else begin
                lph = {i_left_phase_b, i_left_phase_a};
                rph = {i_right_phase_b, i_right_phase_a};
                left_count = left_count + 32'(count_step(left_prev_phase, lph));
                right_count = right_count + 32'(count_step(right_prev_phase, rph));
                left_prev_phase = lph;
                right_prev_phase = rph;
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            drives_seen++;
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("drive %0d: no update expected, got fwd=%0b rev=%0b duty=%0d",
                             drives_seen, o_drive_forward, o_drive_reverse, o_drive_duty);
            end else begin
                want = expected_drives.pop_front();
                if (o_drive_forward !== want.fwd || o_drive_reverse !== want.rev ||
                    o_drive_duty !== want.duty || o_left_delta !== want.left_delta ||
                    o_right_delta !== want.right_delta) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"drive %0d: expected fwd=%0b rev=%0b duty=%0d L=%0d R=%0d,",
                                  " got fwd=%0b rev=%0b duty=%0d L=%0d R=%0d"},
                                 drives_seen, want.fwd, want.rev, want.duty,
                                 want.left_delta, want.right_delta, o_drive_forward,
                                 o_drive_reverse, o_drive_duty, o_left_delta, o_right_delta);
                end
            end
        end
    end

    // Request driver: holds each request until it is taken, then idles.
    always @(negedge i_clk) begin : send_requests
        t_request req;
        bit offer;
        offer = i_in_valid;
        if (i_in_valid && in_taken) begin
            offer = 1'b0;
            send_gap = draw_idle(send_run, send_quiet);
        end
        if (!offer && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                i_kind <= req.kind;
                i_left_phase_a <= req.left_phase[0];
                i_left_phase_b <= req.left_phase[1];
                i_right_phase_a <= req.right_phase[0];
                i_right_phase_b <= req.right_phase[1];
                offer = 1'b1;
            end
        end
        i_in_valid <= offer;
    end

    // Result receiver: stalls for a drawn number of cycles after each update.
    always @(negedge i_clk) begin : take_results
        if (out_taken)
            recv_wait = draw_idle(recv_run, recv_quiet);
        else if (recv_wait > 0)
            recv_wait--;
        i_out_stall <= (hold_left > 0) || (recv_wait > 0);
    end

    // One long receiver hold, so that the block backs up into its input.
    always @(negedge i_clk) begin : long_hold
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_requests >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quadrature_speed_matcher_unit: mismatch");
            $finish;
        end
    end

    task automatic queue_sample(logic [1:0] left_ph, logic [1:0] right_ph);
        t_request req;
        req.kind = 1'b0;
        req.left_phase = left_ph;
        req.right_phase = right_ph;
        pending_requests.push_back(req);
    endtask

    // Phase levels of a tick are ignored, so they carry random bits.
    task automatic queue_tick();
        t_request req;
        req.kind = 1'b1;
        req.left_phase = 2'($urandom_range(0, 3));
        req.right_phase = 2'($urandom_range(0, 3));
        pending_requests.push_back(req);
    endtask

    // Phase pair {B, A} for a position along the forward cycle.
    function automatic logic [1:0] rank_to_phase(int rank);
        logic [1:0] r;
        r = 2'(rank);
        return {r[1] ^ r[0], r[1]};
    endfunction

    // Next encoder position: mostly clean edges in the wheel's direction,
    // some stuck samples, a few skipped edges and some noise.
    function automatic int wander(int rank, int dir, int pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return $urandom_range(0, 3);
        if (roll < 6) return (rank + 2) & 3;
        if ($urandom_range(0, 99) < pct) return (rank + dir) & 3;
        return rank;
    endfunction

    task automatic pick_speeds();
        gen_left_dir = $urandom_range(0, 3) == 0 ? -1 : 1;
        gen_right_dir = $urandom_range(0, 3) == 0 ? -1 : 1;
        gen_left_pct = $urandom_range(0, 100);
        gen_right_pct = $urandom_range(0, 100);
    endtask

    // Random traffic: wheel motion at held speeds with a tick now and then.
    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                queue_tick();
                if ($urandom_range(0, 3) == 0) pick_speeds();
            end else begin
                gen_left_rank = wander(gen_left_rank, gen_left_dir, gen_left_pct);
                gen_right_rank = wander(gen_right_rank, gen_right_dir, gen_right_pct);
                queue_sample(rank_to_phase(gen_left_rank), rank_to_phase(gen_right_rank));
            end
        end
    endtask

    // Wait until every request is taken and every update has arrived.
    task automatic settle();
        bit input_idle;
        forever begin
            @(posedge i_clk);
            input_idle = (pending_requests.size() == 0) && !i_in_valid;
            @(negedge i_clk);
            if (input_idle && expected_drives.size() == 0) break;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DRIVE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : run_test
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset gain and limit. First tick coasts.
        queue_tick();
        // Left wheel one full forward cycle, right stuck.
        queue_sample(2'd2, 2'd0);
        queue_sample(2'd3, 2'd0);
        queue_sample(2'd1, 2'd0);
        queue_sample(2'd0, 2'd0);
        queue_tick();
        // Right wheel one full reverse cycle, left stuck.
        queue_sample(2'd0, 2'd1);
        queue_sample(2'd0, 2'd3);
        queue_sample(2'd0, 2'd2);
        queue_sample(2'd0, 2'd0);
        queue_tick();
        // Skipped edges both ways, bringing the target back to zero.
        queue_sample(2'd1, 2'd3);
        queue_sample(2'd2, 2'd0);
        queue_sample(2'd1, 2'd0);
        queue_sample(2'd0, 2'd0);
        queue_tick();
        // Both phases high on both wheels, then back: equal counts.
        queue_sample(2'd3, 2'd3);
        queue_sample(2'd0, 2'd0);
        queue_tick();
        // Back-to-back ticks with no motion.
        queue_tick();
        settle();

        // Largest gain (upper data bits ignored) and limit.
        write_reg(CFG_LOOP_GAIN, 14'h3FFF);
        write_reg(CFG_MAX_DRIVE, 14'h3FFF);
        queue_random(250);
        settle();

        // Limit dropped to 37.
        write_reg(CFG_MAX_DRIVE, 14'd37);
        queue_random(250);
        settle();

        // Zero gain, written with only upper data bits set.
        write_reg(CFG_LOOP_GAIN, 14'h2C00);
        queue_random(200);
        settle();

        // Zero limit forces the drive to coast.
        write_reg(CFG_LOOP_GAIN, 14'($urandom_range(1, 1023)));
        write_reg(CFG_MAX_DRIVE, 14'd0);
        queue_random(150);
        settle();

        // Random settings.
        write_reg(CFG_LOOP_GAIN, 14'($urandom_range(0, 16383)));
        write_reg(CFG_MAX_DRIVE, 14'($urandom_range(0, 16383)));
        queue_random(250);
        settle();

        // Smallest nonzero gain with the full limit.
        write_reg(CFG_LOOP_GAIN, 14'd1);
        write_reg(CFG_MAX_DRIVE, 14'h3FFF);
        queue_random(250);
        settle();

        if (mismatches == 0 && expected_drives.size() == 0)
            $display("quadrature_speed_matcher_unit: match");
        else
            $display("quadrature_speed_matcher_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/qsm_pkg.sv
sv/qsm_quad_counter.sv
sv/qsm_drive.sv
sv/quadrature_speed_matcher_unit.sv
tb/tb_quadrature_speed_matcher_unit.sv
